// ----- sv/coo_entry_sorter_column_major_core_macros.svh -----
// assertion macros shared by the sorter rtl
// no dependencies; included by files that carry concurrent checks
`ifndef COO_ENTRY_SORTER_COLUMN_MAJOR_CORE_MACROS_SVH
`define COO_ENTRY_SORTER_COLUMN_MAJOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define COO_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define COO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define COO_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define COO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/coo_srt_pkg.sv -----
// shared types and constants of the coo triplet sorter
// no dependencies
package coo_srt_pkg;

    localparam int ROW_W      = 31;
    localparam int COL_W      = 31;
    localparam int VAL_W      = 32;
    localparam int MAX_ENTRIES = 64;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 96;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic drain_shift;
    } cell_ctrl_t;

endpackage

// ----- sv/coo_srt_cell.sv -----
// one cell of the sorting chain: holds one triplet, takes from its neighbors
// depends on coo_srt_pkg
module coo_srt_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  coo_srt_pkg::cell_ctrl_t ctrl,
    input  coo_srt_pkg::entry_t new_entry,
    input  coo_srt_pkg::entry_t left_entry,
    input  logic                left_gt,
    input  coo_srt_pkg::entry_t right_entry,
    output coo_srt_pkg::entry_t cur_entry,
    output logic                gt
);

    logic                            valid_reg;
    logic                            valid_next;
    logic [coo_srt_pkg::COL_W-1:0]   col_reg;
    logic [coo_srt_pkg::COL_W-1:0]   col_next;
    logic [coo_srt_pkg::ROW_W-1:0]   row_reg;
    logic [coo_srt_pkg::ROW_W-1:0]   row_next;
    logic [coo_srt_pkg::VAL_W-1:0]   value_reg;
    logic [coo_srt_pkg::VAL_W-1:0]   value_next;
    coo_srt_pkg::entry_t             pick;
    logic                            load;

    // stored key strictly above the new one (or empty): the new item goes in front
    assign gt = !valid_reg || ({col_reg, row_reg} > {new_entry.col, new_entry.row});

    assign cur_entry = '{valid: valid_reg, col: col_reg, row: row_reg, value: value_reg};

    always_comb
    begin
        pick = cur_entry;
        load = 1'b0;
        if (ctrl.drain_shift)
        begin
            pick = right_entry;
            load = 1'b1;
        end
        else if (ctrl.insert && gt)
        begin
            pick = left_gt ? left_entry : new_entry;
            load = 1'b1;
        end
        valid_next = load ? pick.valid : valid_reg;
        col_next   = pick.col;
        row_next   = pick.row;
        value_next = pick.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            value_reg <= value_next;
        end
    end

endmodule

// ----- sv/coo_entry_sorter_column_major_core.sv -----
// top level of the coo triplet sorter: cell chain plus load/drain control
// depends on coo_srt_pkg, coo_srt_cell and the assertion macro header
//
// Triplets stream in one item per cycle and drop straight into their sorted
// place in a chain of MAX_ENTRIES cells (column first, then row; equal keys
// keep arrival order). An item marked last switches the block to draining,
// which shifts the chain toward its head and sends one sorted item per cycle
// while m_tready is high; no input is taken while draining. Input is ready
// again the cycle after the final result. Items beyond capacity are dropped
// and every result of that set carries overflow on tuser.
`include "coo_entry_sorter_column_major_core_macros.svh"

module coo_entry_sorter_column_major_core
#(
    parameter int MAX_ENTRIES = coo_srt_pkg::MAX_ENTRIES
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // row_index[30:0], col_index[61:31], value_bits[93:62], zero pad
    input  logic [coo_srt_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sorted_row[30:0], sorted_col[61:31], sorted_value[93:62], zero pad
    output logic [coo_srt_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                                m_tlast,
    // overflow[0]
    output logic                                m_tuser
);

    localparam int RW = coo_srt_pkg::ROW_W;
    localparam int CW = coo_srt_pkg::COL_W;
    localparam int VW = coo_srt_pkg::VAL_W;

    typedef enum logic {ST_LOAD, ST_DRAIN} state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic                    dropped_reg;
    logic                    dropped_next;

    coo_srt_pkg::entry_t     cells  [MAX_ENTRIES];
    logic                    gts    [MAX_ENTRIES];
    coo_srt_pkg::entry_t     new_entry;
    coo_srt_pkg::cell_ctrl_t ctrl;
    logic                    in_acc;
    logic                    out_acc;
    logic                    full;

    assign new_entry = '{valid: 1'b1,
                         col:   s_tdata[RW +: CW],
                         row:   s_tdata[0 +: RW],
                         value: s_tdata[RW+CW +: VW]};

    assign full     = cells[MAX_ENTRIES-1].valid;
    assign s_tready = (state_reg == ST_LOAD);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_DRAIN);
    assign out_acc  = m_tvalid && m_tready;

    assign ctrl.insert      = in_acc && !full;
    assign ctrl.drain_shift = out_acc;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            coo_srt_pkg::entry_t left_e;
            coo_srt_pkg::entry_t right_e;
            logic                left_g;
            if (gi == 0)
            begin : g_head
                assign left_e = new_entry;
                assign left_g = 1'b0;
            end
            else
            begin : g_body
                assign left_e = cells[gi-1];
                assign left_g = gts[gi-1];
            end
            if (gi == MAX_ENTRIES-1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_mid
                assign right_e = cells[gi+1];
            end
            coo_srt_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .left_gt     (left_g),
                .right_entry (right_e),
                .cur_entry   (cells[gi]),
                .gt          (gts[gi])
            );
        end
    endgenerate

    assign m_tdata = {{(coo_srt_pkg::OUT_DATA_W-RW-CW-VW){1'b0}},
                      cells[0].value, cells[0].col, cells[0].row};
    // head is the final item once the second cell is empty
    assign m_tlast = !cells[1].valid;
    assign m_tuser = dropped_reg;

    always_comb
    begin
        state_next   = state_reg;
        dropped_next = dropped_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    dropped_next = dropped_reg || full;
                    if (s_tlast)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_acc && m_tlast)
                begin
                    state_next   = ST_LOAD;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            dropped_reg <= dropped_next;
        end
    end

    `COO_ASSERT_SAME(a_drain_has_head, clk, rst_n, m_tvalid, cells[0].valid, "drain with empty head cell")
    `COO_ASSERT_NEXT(a_last_in_drains, clk, rst_n, s_tvalid && s_tready && s_tlast, m_tvalid, "last item did not start drain")
    `COO_ASSERT_NEXT(a_last_out_clears, clk, rst_n, m_tvalid && m_tready && m_tlast, !cells[0].valid && !m_tuser, "chain not empty after final item")

endmodule
